FILE: src/bsg_pkg.sv
// Shared types and constants for the BMP-to-gray stream unit.
// No dependencies; imported by bsg_gray, bsg_parser and the top level.
package bsg_pkg;

  localparam int SIDE_DEFAULT = 28;

  localparam int PIX_VAL_W   = 8;
  localparam int PIX_IDX_W   = 10;
  localparam int STATUS_W    = 3;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_PAYLD_W = PIX_VAL_W + PIX_IDX_W;
  localparam int OUT_TDATA_W = ((OUT_PAYLD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_PAYLD_W;

  localparam logic [15:0] BMP_MAGIC  = 16'h4D42;
  localparam logic [31:0] HEADER_LEN = 32'd54;
  localparam logic [5:0]  MAGIC_CHECK_POS = 6'd13;
  localparam logic [5:0]  HEADER_LAST_POS = 6'd53;

  // Q0.16 luma weights
  localparam logic [15:0] W_RED   = 16'd19595;
  localparam logic [15:0] W_GREEN = 16'd38470;
  localparam logic [15:0] W_BLUE  = 16'd7471;

  localparam logic [15:0] DEPTH_8  = 16'd8;
  localparam logic [15:0] DEPTH_24 = 16'd24;
  localparam logic [15:0] DEPTH_32 = 16'd32;

  typedef enum logic [STATUS_W-1:0] {
    ST_PIXEL      = 3'd0,
    ST_NOT_BMP    = 3'd1,
    ST_BAD_SIZE   = 3'd2,
    ST_BAD_DEPTH  = 3'd3,
    ST_TRUNCATED  = 3'd4,
    ST_BAD_OFFSET = 3'd5
  } status_t;

  typedef struct packed {
    logic [PIX_VAL_W-1:0] value;
    logic [PIX_IDX_W-1:0] index;
    status_t              status;
    logic                 last;
  } result_t;

endpackage

FILE: src/bsg_gray.sv
// Fixed-point BGR to gray conversion, Q0.16 weights, truncated.
// Depends on bsg_pkg for the weights.
module bsg_gray (
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output logic [7:0] gray
);
  import bsg_pkg::*;

  logic [23:0] prod_r;
  logic [23:0] prod_g;
  logic [23:0] prod_b;
  logic [23:0] sum;

  assign prod_r = 24'(W_RED)   * 24'(red);
  assign prod_g = 24'(W_GREEN) * 24'(green);
  assign prod_b = 24'(W_BLUE)  * 24'(blue);
  assign sum    = prod_r + prod_g + prod_b;
  assign gray   = sum[23:16];

endmodule

FILE: src/bsg_parser.sv
// Header parse, pixel walk and error detection for one file byte per step.
// Depends on bsg_pkg and bsg_gray.
module bsg_parser #(
  parameter int SIDE = bsg_pkg::SIDE_DEFAULT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       data_byte,
  input  logic             file_start,
  input  logic             file_end,
  output logic             res_valid,
  output bsg_pkg::result_t res
);
  import bsg_pkg::*;

  localparam int PW   = $clog2(4 * SIDE);
  localparam int RLW  = $clog2(4 * SIDE + 1);
  localparam int XW   = $clog2(SIDE + 1);
  localparam int RW   = $clog2(SIDE + 1);
  localparam int LINW = $clog2(SIDE * SIDE + 1);
  localparam int CW   = (LINW > PIX_IDX_W) ? LINW : PIX_IDX_W;

  localparam logic [RLW-1:0] ROW_LEN1 = RLW'(((SIDE + 3) / 4) * 4);
  localparam logic [RLW-1:0] ROW_LEN3 = RLW'(((3 * SIDE + 3) / 4) * 4);
  localparam logic [RLW-1:0] ROW_LEN4 = RLW'(4 * SIDE);
  localparam logic [XW-1:0]  SIDE_X   = XW'(SIDE);
  localparam logic [XW-1:0]  LAST_X   = XW'(SIDE - 1);
  localparam logic [RW-1:0]  LAST_ROW = RW'(SIDE - 1);
  localparam logic [31:0]    SIDE_32  = 32'(SIDE);
  localparam logic [31:0]    NSIDE_32 = 32'(0) - 32'(SIDE);
  localparam logic [CW-1:0]  SIDE_C   = CW'(SIDE);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_SKIP   = 2'd1,
    PH_PIXELS = 2'd2,
    PH_IDLE   = 2'd3
  } phase_t;

  phase_t        phase_r, phase_nxt, phase_c;
  logic [31:0]   cnt_r, cnt_nxt, cnt_c;
  logic [15:0]   magic_r, magic_nxt;
  logic [31:0]   ofs_r, ofs_nxt;
  logic [31:0]   wid_r, wid_nxt;
  logic [31:0]   hgt_r, hgt_nxt;
  logic [15:0]   depth_r, depth_nxt;
  logic [PW-1:0] pos_r, pos_nxt, pos_c;
  logic [XW-1:0] x_r, x_nxt, x_c;
  logic [1:0]    ch_r, ch_nxt, ch_c;
  logic [RW-1:0] rows_r, rows_nxt, rows_c;
  logic [7:0]    blue_r, blue_nxt;
  logic [7:0]    green_r, green_nxt;

  logic           pixel_byte;
  logic           bpp1, bpp3;
  logic           ch_last;
  logic           emit;
  logic           last;
  logic [RLW-1:0] pos1;
  logic [RLW-1:0] row_len;
  logic [RW-1:0]  row;
  logic [CW-1:0]  lin_idx;
  logic [7:0]     gray_rgb;
  logic [7:0]     gray;
  status_t        err;

  bsg_gray u_gray (
    .red   (data_byte),
    .green (green_r),
    .blue  (blue_r),
    .gray  (gray_rgb)
  );

  always_comb begin
    phase_c = file_start ? PH_HEADER : phase_r;
    cnt_c   = file_start ? '0 : cnt_r;
    pos_c   = file_start ? '0 : pos_r;
    x_c     = file_start ? '0 : x_r;
    ch_c    = file_start ? '0 : ch_r;
    rows_c  = file_start ? '0 : rows_r;

    phase_nxt = phase_c;
    cnt_nxt   = cnt_c;
    magic_nxt = magic_r;
    ofs_nxt   = ofs_r;
    wid_nxt   = wid_r;
    hgt_nxt   = hgt_r;
    depth_nxt = depth_r;
    pos_nxt   = pos_c;
    x_nxt     = x_c;
    ch_nxt    = ch_c;
    rows_nxt  = rows_c;
    blue_nxt  = blue_r;
    green_nxt = green_r;

    err        = ST_PIXEL;
    pixel_byte = 1'b0;
    emit       = 1'b0;
    last       = 1'b0;
    gray       = '0;

    bpp1    = (depth_r == DEPTH_8);
    bpp3    = (depth_r == DEPTH_24);
    ch_last = bpp1 || (bpp3 && ch_c == 2'd2) || (!bpp1 && !bpp3 && ch_c == 2'd3);
    row_len = bpp1 ? ROW_LEN1 : (bpp3 ? ROW_LEN3 : ROW_LEN4);
    pos1    = RLW'(pos_c) + RLW'(1);
    row     = hgt_r[31] ? rows_c : LAST_ROW - rows_c;
    lin_idx = CW'(row) * SIDE_C + CW'(x_c);

    if (phase_c != PH_IDLE) begin
      cnt_nxt = cnt_c + 32'd1;
      case (phase_c)
        PH_HEADER: begin
          case (cnt_c[5:0])
            6'd0:  magic_nxt[7:0]   = data_byte;
            6'd1:  magic_nxt[15:8]  = data_byte;
            6'd10: ofs_nxt[7:0]     = data_byte;
            6'd11: ofs_nxt[15:8]    = data_byte;
            6'd12: ofs_nxt[23:16]   = data_byte;
            6'd13: ofs_nxt[31:24]   = data_byte;
            6'd18: wid_nxt[7:0]     = data_byte;
            6'd19: wid_nxt[15:8]    = data_byte;
            6'd20: wid_nxt[23:16]   = data_byte;
            6'd21: wid_nxt[31:24]   = data_byte;
            6'd22: hgt_nxt[7:0]     = data_byte;
            6'd23: hgt_nxt[15:8]    = data_byte;
            6'd24: hgt_nxt[23:16]   = data_byte;
            6'd25: hgt_nxt[31:24]   = data_byte;
            6'd28: depth_nxt[7:0]   = data_byte;
            6'd29: depth_nxt[15:8]  = data_byte;
            default: ;
          endcase
          if (cnt_c[5:0] == MAGIC_CHECK_POS && magic_r != BMP_MAGIC) begin
            err = ST_NOT_BMP;
          end else if (cnt_c[5:0] == HEADER_LAST_POS) begin
            if (wid_r != SIDE_32 || (hgt_r != SIDE_32 && hgt_r != NSIDE_32)) begin
              err = ST_BAD_SIZE;
            end else if (depth_r != DEPTH_8 && depth_r != DEPTH_24 &&
                         depth_r != DEPTH_32) begin
              err = ST_BAD_DEPTH;
            end else if (ofs_r < HEADER_LEN) begin
              err = ST_BAD_OFFSET;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          if (cnt_c == ofs_r) begin
            phase_nxt  = PH_PIXELS;
            pixel_byte = 1'b1;
          end
        end
        PH_PIXELS: pixel_byte = 1'b1;
        default: ;
      endcase
    end

    if (pixel_byte) begin
      if (x_c < SIDE_X) begin
        if (bpp1) begin
          gray = data_byte;
          emit = 1'b1;
        end else if (ch_c == 2'd0) begin
          blue_nxt = data_byte;
        end else if (ch_c == 2'd1) begin
          green_nxt = data_byte;
        end else if (ch_c == 2'd2) begin
          gray = gray_rgb;
          emit = 1'b1;
        end
        if (ch_last) begin
          ch_nxt = '0;
          x_nxt  = x_c + XW'(1);
        end else begin
          ch_nxt = ch_c + 2'd1;
        end
        if (emit) begin
          last = (rows_c == LAST_ROW) && (x_c == LAST_X);
          if (last) begin
            phase_nxt = PH_IDLE;
          end
        end
      end
      if (pos1 >= row_len) begin
        pos_nxt  = '0;
        x_nxt    = '0;
        ch_nxt   = '0;
        rows_nxt = rows_c + RW'(1);
      end else begin
        pos_nxt = pos1[PW-1:0];
      end
    end

    if (err == ST_PIXEL && file_end && phase_nxt != PH_IDLE && phase_c != PH_IDLE) begin
      err = ST_TRUNCATED;
    end
    if (err != ST_PIXEL) begin
      phase_nxt = PH_IDLE;
    end

    res_valid = (err != ST_PIXEL) || emit;
    if (err != ST_PIXEL) begin
      res.value  = '0;
      res.index  = '0;
      res.status = err;
      res.last   = 1'b0;
    end else begin
      res.value  = gray;
      res.index  = lin_idx[PIX_IDX_W-1:0];
      res.status = ST_PIXEL;
      res.last   = last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      cnt_r   <= '0;
      pos_r   <= '0;
      x_r     <= '0;
      ch_r    <= '0;
      rows_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      pos_r   <= pos_nxt;
      x_r     <= x_nxt;
      ch_r    <= ch_nxt;
      rows_r  <= rows_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      magic_r <= magic_nxt;
      ofs_r   <= ofs_nxt;
      wid_r   <= wid_nxt;
      hgt_r   <= hgt_nxt;
      depth_r <= depth_nxt;
      blue_r  <= blue_nxt;
      green_r <= green_nxt;
    end
  end

endmodule

FILE: src/bmp_stream_to_gray_image_unit.sv
// Top level: input word register, BMP parser with gray conversion, result register.
// Depends on bsg_pkg and bsg_parser.
//
// Takes a BMP file one byte per word (tuser marks the first byte of a file, tlast the
// final byte) and emits one word per gray pixel of a SIDE x SIDE image with its
// row-major index counted from the top row, or a single error word (value and index zero,
// status nonzero) after which the unit ignores bytes until the next file start.
// Throughput is one byte per clock unless a held result waits; each byte passes an input
// register and then a result register on its way to the output.
// The per-byte parse, counter update and three constant multiplies form the one logic
// stage between those registers. tready on the input drops only while a held result
// waits.
module bmp_stream_to_gray_image_unit #(
  parameter int SIDE = bsg_pkg::SIDE_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bsg_pkg::IN_TDATA_W-1:0]  in_tdata,   // data_byte[7:0]
  input  logic                            in_tuser,   // file_start
  input  logic                            in_tlast,   // file_end
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bsg_pkg::OUT_TDATA_W-1:0] out_tdata,  // pixel_value, pixel_index, zero pad
  output logic [bsg_pkg::STATUS_W-1:0]    out_tuser,  // status[2:0]
  output logic                            out_tlast   // last_pixel
);
  import bsg_pkg::*;

  logic                  in_v_r;
  logic [IN_TDATA_W-1:0] in_data_r;
  logic                  in_fs_r;
  logic                  in_fe_r;
  logic                  out_v_r;
  result_t               out_res_r;
  logic                  step;
  logic                  res_valid;
  result_t               res;

  assign step      = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || step;

  bsg_parser #(
    .SIDE (SIDE)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .data_byte  (in_data_r),
    .file_start (in_fs_r),
    .file_end   (in_fe_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (!out_v_r || out_tready) begin
        out_v_r <= step && res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r <= in_tdata;
      in_fs_r   <= in_tuser;
      in_fe_r   <= in_tlast;
    end
    if (step && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_res_r.index, out_res_r.value};
  assign out_tuser  = out_res_r.status;
  assign out_tlast  = out_res_r.last;

endmodule

FILE: tb/sv/bmp_stream_to_gray_image_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for bmp_stream_to_gray_image_unit: feeds BMP files byte by byte,
// predicts gray pixels and error words in a scoreboard class, checks every result word.
// Depends on bsg_pkg and the unit's RTL.
module bmp_stream_to_gray_image_unit_tb;
  import bsg_pkg::*;

  localparam int SIDE = SIDE_DEFAULT;
  localparam logic [31:0] NEG_SIDE = 32'(-SIDE);
  localparam int ITEMS = 1650;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 20;

  typedef enum logic [1:0] {PH_HEADER, PH_SKIP, PH_PIXELS, PH_IDLE} parse_phase_t;

  class gray_image_scoreboard;
    parse_phase_t phase;
    logic [31:0] byte_count, data_ofs, img_width, img_height;
    logic [15:0] magic_word, bit_depth;
    int unsigned row_pos, rows_done;
    logic [7:0] blue_hold, green_hold, red_hold;
    result_t expected_pixels[$];
    int unsigned mismatches;

    function new();
      clear();
      mismatches = 0;
    endfunction

    function void clear();
      phase = PH_HEADER;
      byte_count = 0;
      data_ofs = 0;
      img_width = 0;
      img_height = 0;
      magic_word = 0;
      bit_depth = 0;
      row_pos = 0;
      rows_done = 0;
      blue_hold = 0;
      green_hold = 0;
      red_hold = 0;
    endfunction

    function status_t header_status();
      if (img_width != SIDE || (img_height != SIDE && img_height != NEG_SIDE))
        return ST_BAD_SIZE;
      if (bit_depth != DEPTH_8 && bit_depth != DEPTH_24 && bit_depth != DEPTH_32)
        return ST_BAD_DEPTH;
      if (data_ofs < HEADER_LEN)
        return ST_BAD_OFFSET;
      return ST_PIXEL;
    endfunction

    // one accepted input word
    function void note_byte(logic [7:0] b, bit fs, bit fe);
      logic [31:0] idx;
      status_t err;
      bit emit, last, pix;
      int unsigned bpp, used, row_len, x, ch, acc, row;
      logic [7:0] gray;
      logic [9:0] index;
      result_t r;
      err = ST_PIXEL;
      emit = 0;
      last = 0;
      pix = 0;
      gray = 0;
      index = 0;
      if (fs) clear();
      if (phase == PH_IDLE) return;
      idx = byte_count;
      byte_count = idx + 1;
      case (phase)
        PH_HEADER: begin
          if (idx <= 1) magic_word[8*idx +: 8] = b;
          else if (idx >= 10 && idx <= 13) data_ofs[8*(idx-10) +: 8] = b;
          else if (idx >= 18 && idx <= 21) img_width[8*(idx-18) +: 8] = b;
          else if (idx >= 22 && idx <= 25) img_height[8*(idx-22) +: 8] = b;
          else if (idx >= 28 && idx <= 29) bit_depth[8*(idx-28) +: 8] = b;
          if (idx == MAGIC_CHECK_POS && magic_word != BMP_MAGIC) begin
            err = ST_NOT_BMP;
          end else if (idx == HEADER_LAST_POS) begin
            err = header_status();
            if (err == ST_PIXEL) phase = PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (idx == data_ofs) begin
            phase = PH_PIXELS;
            pix = 1;
          end
        end
        default: pix = 1;
      endcase

      if (pix) begin
        bpp = bit_depth / 8;
        used = SIDE * bpp;
        row_len = (used + 3) / 4 * 4;
        if (row_pos < used) begin
          x = row_pos / bpp;
          ch = row_pos % bpp;
          if (bpp == 1) begin
            gray = b;
            emit = 1;
          end else if (ch == 0) begin
            blue_hold = b;
          end else if (ch == 1) begin
            green_hold = b;
          end else if (ch == 2) begin
            red_hold = b;
            acc = W_RED * red_hold + W_GREEN * green_hold + W_BLUE * blue_hold;
            gray = 8'(acc >> 16);
            emit = 1;
          end
          if (emit) begin
            row = img_height[31] ? rows_done : SIDE - 1 - rows_done;
            index = 10'(row * SIDE + x);
            last = (rows_done == SIDE - 1) && (x == SIDE - 1);
            if (last) phase = PH_IDLE;
          end
        end
        row_pos++;
        if (row_pos >= row_len) begin
          row_pos = 0;
          rows_done++;
        end
      end

      if (err == ST_PIXEL && fe && phase != PH_IDLE) err = ST_TRUNCATED;

      if (err != ST_PIXEL) begin
        phase = PH_IDLE;
        r.value = 0;
        r.index = 0;
        r.status = err;
        r.last = 0;
        expected_pixels.push_back(r);
      end else if (emit) begin
        r.value = gray;
        r.index = index;
        r.status = ST_PIXEL;
        r.last = last;
        expected_pixels.push_back(r);
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [7:0] value, logic [9:0] index, status_t status,
                               logic last);
      result_t want;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word, expected none, got value %0d index %0d status %0d last %0d",
                 $time, value, index, status, last);
        return;
      end
      want = expected_pixels.pop_front();
      compare_field("value", want.value, value);
      compare_field("index", want.index, index);
      compare_field("status", want.status, status);
      compare_field("last", want.last, last);
    endfunction

    function int unsigned pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0] out_tuser;
  logic out_tlast;

  gray_image_scoreboard sb;
  logic [7:0] file_bytes[$];
  bit no_gaps = 0;
  int sent_bytes = 0;
  int stall_left = 0;
  int idle_cycles = 0;

  bmp_stream_to_gray_image_unit #(.SIDE(SIDE)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic int image_bytes(logic [15:0] depth);
    return SIDE * ((SIDE * (depth / 8) + 3) / 4 * 4);
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[PIX_VAL_W-1:0], out_tdata[PIX_VAL_W +: PIX_IDX_W],
                      status_t'(out_tuser), out_tlast);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // called at a rising edge; returns at the edge where the word is taken
  task automatic push_byte(input logic [7:0] b, input bit fs, input bit fe);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tuser <= fs;
    in_tlast <= fe;
    @(posedge clk iff in_tready);
    sb.note_byte(b, fs, fe);
    sent_bytes++;
  endtask

  task automatic send_file(input bit mark_start, input bit mark_end);
    for (int i = 0; i < file_bytes.size(); i++)
      push_byte(file_bytes[i], mark_start && i == 0, mark_end && i == file_bytes.size() - 1);
  endtask

  task automatic add_random(input int n);
    for (int i = 0; i < n; i++) file_bytes.push_back(rand_byte());
  endtask

  task automatic cut_file(input int n);
    while (file_bytes.size() > n) void'(file_bytes.pop_back());
  endtask

  task automatic build_header(input logic [15:0] magic, input logic [31:0] offset,
                              input logic [31:0] width, input logic [31:0] height,
                              input logic [15:0] depth);
    logic [7:0] b;
    file_bytes.delete();
    for (int i = 0; i < HEADER_LEN; i++) begin
      b = 8'($urandom);
      if (i < 2) b = magic[8*i +: 8];
      else if (i >= 10 && i < 14) b = offset[8*(i-10) +: 8];
      else if (i >= 18 && i < 22) b = width[8*(i-18) +: 8];
      else if (i >= 22 && i < 26) b = height[8*(i-22) +: 8];
      else if (i >= 28 && i < 30) b = depth[8*(i-28) +: 8];
      file_bytes.push_back(b);
    end
  endtask

  task automatic header_case(input logic [15:0] magic, input logic [31:0] offset,
                             input logic [31:0] width, input logic [31:0] height,
                             input logic [15:0] depth, input int len, input bit mark_end);
    build_header(magic, offset, width, height, depth);
    if (len < HEADER_LEN) cut_file(len);
    else add_random(len - HEADER_LEN);
    send_file(1'b1, mark_end);
  endtask

  task automatic run_directed();
    // first file right after reset, no start flag, complete top-down 8-bit image
    build_header(BMP_MAGIC, HEADER_LEN, SIDE, NEG_SIDE, DEPTH_8);
    for (int i = 0; i < image_bytes(DEPTH_8); i++)
      file_bytes.push_back(i % 4 == 0 ? 8'h00 : i % 4 == 1 ? 8'hFF : 8'($urandom));
    send_file(1'b0, 1'b1);
    // stray words after completion are ignored
    push_byte(8'hFF, 1'b0, 1'b1);
    push_byte(8'h00, 1'b0, 1'b0);

    header_case(16'h4D43, HEADER_LEN, SIDE, SIDE, DEPTH_8, 20, 1'b1);
    header_case(16'h424D, HEADER_LEN, SIDE, NEG_SIDE, DEPTH_24, 14, 1'b1);
    header_case(BMP_MAGIC, HEADER_LEN, SIDE + 1, SIDE, DEPTH_8, 60, 1'b0);
    header_case(BMP_MAGIC, HEADER_LEN, SIDE, SIDE - 1, DEPTH_8, 54, 1'b1);
    header_case(BMP_MAGIC, HEADER_LEN, SIDE, 32'h8000_0000 | SIDE, DEPTH_24, 56, 1'b0);
    header_case(BMP_MAGIC, HEADER_LEN, 32'h0001_0000 | SIDE, SIDE, DEPTH_32, 54, 1'b0);
    header_case(BMP_MAGIC, HEADER_LEN, SIDE, SIDE, 16'd16, 58, 1'b1);
    header_case(BMP_MAGIC, HEADER_LEN, SIDE, NEG_SIDE, 16'h0118, 54, 1'b0);
    header_case(BMP_MAGIC, 32'd53, SIDE, SIDE, DEPTH_8, 54, 1'b1);
    header_case(BMP_MAGIC, 32'd0, SIDE, NEG_SIDE, DEPTH_32, 60, 1'b0);
    header_case(BMP_MAGIC, 32'h0100_0036, SIDE, SIDE, DEPTH_8, 70, 1'b1);
    header_case(BMP_MAGIC, HEADER_LEN, 32'd0, SIDE, 16'd0, 54, 1'b0);
    header_case(BMP_MAGIC, 32'd10, SIDE, SIDE, 16'd16, 54, 1'b0);
    header_case(BMP_MAGIC, HEADER_LEN, SIDE, SIDE, DEPTH_8, 30, 1'b1);
    header_case(BMP_MAGIC, HEADER_LEN, SIDE, SIDE, DEPTH_24, 54, 1'b1);
    header_case(BMP_MAGIC, 32'd60, SIDE, SIDE, DEPTH_8, 58, 1'b1);
    // cut short with no end mark; the next start flag restarts the parser
    header_case(BMP_MAGIC, HEADER_LEN, SIDE, SIDE, DEPTH_8, 30, 1'b0);

    // bottom-up 24-bit, end mark on a red byte replaces that pixel
    build_header(BMP_MAGIC, HEADER_LEN, SIDE, SIDE, DEPTH_24);
    repeat (3) file_bytes.push_back(8'hFF);
    repeat (3) file_bytes.push_back(8'h00);
    add_random(12);
    send_file(1'b1, 1'b1);

    // bottom-up 32-bit with a skipped gap, end mark on an alpha byte
    build_header(BMP_MAGIC, 32'd70, SIDE, SIDE, DEPTH_32);
    add_random(16 + 20);
    send_file(1'b1, 1'b1);
  endtask

  task automatic run_random_file();
    int kind, full, cut;
    logic [15:0] depth, magic;
    logic [31:0] offset, width, height;
    no_gaps = ($urandom_range(0, 4) == 0);
    kind = $urandom_range(0, 99);
    case ($urandom_range(0, 2))
      0: depth = DEPTH_8;
      1: depth = DEPTH_24;
      default: depth = DEPTH_32;
    endcase
    height = $urandom_range(0, 1) ? 32'(SIDE) : NEG_SIDE;
    offset = HEADER_LEN + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 24) : 0);
    magic = BMP_MAGIC;
    width = SIDE;
    if (kind < 70) begin
      full = image_bytes(depth);
      build_header(magic, offset, width, height, depth);
      add_random(offset - HEADER_LEN);
      if ($urandom_range(0, 99) < ((depth == DEPTH_8) ? 20 : 4))
        add_random(full + ($urandom_range(0, 1) ? 0 : $urandom_range(1, 6)));
      else
        add_random($urandom_range(0, 240));
      send_file(1'b1, $urandom_range(0, 4) != 0);
    end else if (kind < 88) begin
      case ($urandom_range(0, 4))
        0: magic = 16'($urandom);
        1: width = $urandom_range(0, 1) ? 32'($urandom) : 32'($urandom_range(0, 2 * SIDE));
        2: height = $urandom_range(0, 1) ? 32'($urandom) : 32'($urandom_range(0, 2 * SIDE));
        3: depth = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 40));
        default: offset = $urandom_range(0, 1) ? 32'($urandom) : 32'($urandom_range(0, 60));
      endcase
      build_header(magic, offset, width, height, depth);
      cut = $urandom_range(1, 80);
      if (cut < HEADER_LEN) cut_file(cut);
      else add_random(cut - HEADER_LEN);
      send_file($urandom_range(0, 7) != 0, $urandom_range(0, 1));
    end else begin
      file_bytes.delete();
      add_random($urandom_range(1, 60));
      for (int i = 0; i < file_bytes.size(); i++)
        push_byte(file_bytes[i], i == 0 && $urandom_range(0, 1), $urandom_range(0, 15) == 0);
    end
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    while (sent_bytes < ITEMS) run_random_file();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: filelist.f
src/bsg_pkg.sv
src/bsg_gray.sv
src/bsg_parser.sv
src/bmp_stream_to_gray_image_unit.sv
tb/sv/bmp_stream_to_gray_image_unit_tb.sv
